// ----- hw/rtl/cdad_pkg.sv -----
package cdad_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_STEP
    } t_state;

    // width of the running day count: 31 + 65535 fits in 17 bits
    localparam int unsigned DAY_W   = 17;
    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned R400_W  = 9;

    // leap cycle and the restoring reduction of the year by it
    localparam logic [DAY_W-1:0]  CYCLE_400  = DAY_W'(400);
    localparam int unsigned       MOD_STEPS  = 8;
    localparam int unsigned       SHIFT_W    = $clog2(MOD_STEPS);
    localparam logic [R400_W-1:0] R400_LAST  = R400_W'(399);
    localparam logic [R400_W-1:0] CENT_1     = R400_W'(100);
    localparam logic [R400_W-1:0] CENT_2     = R400_W'(200);
    localparam logic [R400_W-1:0] CENT_3     = R400_W'(300);

    localparam logic [MONTH_W-1:0] DECEMBER  = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] JANUARY   = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);

    localparam logic [LEN_W-1:0] LEN_LONG  = LEN_W'(31);
    localparam logic [LEN_W-1:0] LEN_SHORT = LEN_W'(30);
    localparam logic [LEN_W-1:0] LEN_LEAP  = LEN_W'(29);
    localparam logic [LEN_W-1:0] LEN_FEB   = LEN_W'(28);
    localparam logic [LEN_W-1:0] LEN_NONE  = LEN_W'(0);

    // operand pair for the shared subtractor
    typedef struct packed {
        logic [DAY_W-1:0] a;
        logic [DAY_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [DAY_W-1:0] diff;
        logic             borrow;
    } t_alu_rsp;

endpackage

// ----- hw/rtl/cdad_alu.sv -----
module cdad_alu (
    input  cdad_pkg::t_alu_req i_req,
    output cdad_pkg::t_alu_rsp o_rsp
);

    logic [cdad_pkg::DAY_W:0] w_full;

    // one extra bit carries the borrow
    assign w_full       = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_rsp.diff   = w_full[cdad_pkg::DAY_W-1:0];
    assign o_rsp.borrow = w_full[cdad_pkg::DAY_W];

endmodule

// ----- hw/rtl/cdad_mlen.sv -----
module cdad_mlen (
    input  logic [cdad_pkg::MONTH_W-1:0] i_month,
    input  logic [cdad_pkg::R400_W-1:0]  i_r400,
    output logic [cdad_pkg::LEN_W-1:0]   o_len
);

    logic w_leap;

    // year mod 400 also carries year mod 4 in its low bits
    assign w_leap = (i_r400 == '0) ||
                    ((i_r400[1:0] == 2'b00) && (i_r400 != cdad_pkg::CENT_1) &&
                     (i_r400 != cdad_pkg::CENT_2) && (i_r400 != cdad_pkg::CENT_3));

    always_comb begin
        case (i_month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
                o_len = cdad_pkg::LEN_LONG;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                o_len = cdad_pkg::LEN_SHORT;
            end
            cdad_pkg::FEBRUARY: begin
                o_len = w_leap ? cdad_pkg::LEN_LEAP : cdad_pkg::LEN_FEB;
            end
            default: begin
                o_len = cdad_pkg::LEN_NONE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/calendar_date_add_days_core.sv -----
// channel  | direction | handshake         | payload
// ---------+-----------+-------------------+--------------------------------------------
// command  | in        | start, busy       | i_start_day, i_start_month, i_start_year,
//          |           |                   | i_days_to_add
// result   | out       | o_done (strobe)   | o_new_day, o_new_month, o_new_year,
//          |           |                   | o_year_overflow
//
// a word is taken at a clock edge with start high and busy low
// the year is first reduced mod 400 by restoring trial subtraction of 400<<k, then each month
// step runs through the single shared subtractor, followed by one final compare
// o_done is high for one cycle, result ports hold their value until the next word starts
// synchronous active-low reset returns the sequencer to idle and drops the strobe
// the receiver cannot stall: a result is taken in its strobe cycle, and a new word may
// be started in that same cycle
module calendar_date_add_days_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  i_start_day,
    input  logic [3:0]  i_start_month,
    input  logic [15:0] i_start_year,
    input  logic [15:0] i_days_to_add,
    output logic        o_done,
    output logic [4:0]  o_new_day,
    output logic [3:0]  o_new_month,
    output logic [15:0] o_new_year,
    output logic        o_year_overflow
);

    cdad_pkg::t_state r_state, n_state;

    // working date: day count, month, year
    logic [cdad_pkg::DAY_W-1:0]   r_day, n_day;
    logic [cdad_pkg::MONTH_W-1:0] r_month, n_month;
    logic [cdad_pkg::YEAR_W-1:0]  r_year, n_year;
    // year remainder: reduced by 400<<k during the prelude, then kept as year mod 400
    logic [cdad_pkg::YEAR_W-1:0]  r_rem, n_rem;
    logic [cdad_pkg::SHIFT_W-1:0] r_k, n_k;
    logic                         r_ovf, n_ovf;
    logic                         r_done, n_done;

    cdad_pkg::t_alu_req           w_req;
    cdad_pkg::t_alu_rsp           w_rsp;
    logic [cdad_pkg::LEN_W-1:0]   w_len;
    logic                         w_more;

    // the one subtractor shared by both phases
    cdad_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // length of the current month from year mod 400
    cdad_mlen u_mlen (
        .i_month (r_month),
        .i_r400  (r_rem[cdad_pkg::R400_W-1:0]),
        .o_len   (w_len)
    );

    // operand select: prelude trial-subtracts 400<<k, stepping subtracts the month length
    always_comb begin
        if (r_state == cdad_pkg::ST_MOD) begin
            w_req.a = {1'b0, r_rem};
            w_req.b = cdad_pkg::CYCLE_400 << r_k;
        end else begin
            w_req.a = r_day;
            w_req.b = {{(cdad_pkg::DAY_W-cdad_pkg::LEN_W){1'b0}}, w_len};
        end
    end

    // day still beyond the month: no borrow and a nonzero difference
    assign w_more = !w_rsp.borrow && (w_rsp.diff != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdad_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_day   <= n_day;
        r_month <= n_month;
        r_year  <= n_year;
        r_rem   <= n_rem;
        r_k     <= n_k;
        r_ovf   <= n_ovf;
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_rem   = r_rem;
        n_k     = r_k;
        n_ovf   = r_ovf;
        case (r_state)
            cdad_pkg::ST_IDLE: begin
                if (start) begin
                    n_day   = cdad_pkg::DAY_W'(i_start_day) + cdad_pkg::DAY_W'(i_days_to_add);
                    n_month = i_start_month;
                    n_year  = i_start_year;
                    n_rem   = i_start_year;
                    n_k     = cdad_pkg::SHIFT_W'(cdad_pkg::MOD_STEPS - 1);
                    n_ovf   = 1'b0;
                    n_state = cdad_pkg::ST_MOD;
                end
            end
            cdad_pkg::ST_MOD: begin
                // restoring reduction, one shifted multiple of 400 a cycle
                if (!w_rsp.borrow) begin
                    n_rem = w_rsp.diff[cdad_pkg::YEAR_W-1:0];
                end
                n_k = r_k - 1'b1;
                if (r_k == '0) begin
                    n_state = cdad_pkg::ST_STEP;
                end
            end
            cdad_pkg::ST_STEP: begin
                if (w_more) begin
                    n_day = w_rsp.diff;
                    if (r_month >= cdad_pkg::DECEMBER) begin
                        // out-of-range months above twelve roll over like december
                        n_month = cdad_pkg::JANUARY;
                        n_year  = r_year + 1'b1;
                        if (r_year == '1) begin
                            // year wraps to 0, which is a leap year
                            n_ovf = 1'b1;
                            n_rem = '0;
                        end else if (r_rem[cdad_pkg::R400_W-1:0] == cdad_pkg::R400_LAST) begin
                            n_rem = '0;
                        end else begin
                            n_rem = r_rem + 1'b1;
                        end
                    end else begin
                        n_month = r_month + 1'b1;
                    end
                end else begin
                    n_done  = 1'b1;
                    n_state = cdad_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cdad_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != cdad_pkg::ST_IDLE);
    assign o_done          = r_done;
    assign o_new_day       = r_day[4:0];
    assign o_new_month     = r_month;
    assign o_new_year      = r_year;
    assign o_year_overflow = r_ovf;

endmodule

// ----- hw/rtl/cdad_checker.sv -----
module cdad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [4:0]  o_new_day,
    input logic [3:0]  o_new_month
);

    // strobe lasts one cycle: no result can follow straight after another
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // an accepted word makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("word accepted but block not busy");

    // a result is only shown once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // a nonzero day always lands in a real month
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_new_day != 5'd0)) |-> ((o_new_month >= 4'd1) && (o_new_month <= 4'd12)))
        else $error("normalised date has month out of range");

endmodule

bind calendar_date_add_days_core cdad_checker u_cdad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_new_day   (o_new_day),
    .o_new_month (o_new_month)
);
